>>> design/nearest_match_index_finder_core_assert.svh
// assertion macros for the nearest match index finder
`ifndef NEAREST_MATCH_INDEX_FINDER_CORE_ASSERT_SVH
`define NEAREST_MATCH_INDEX_FINDER_CORE_ASSERT_SVH

`ifndef SYNTH
`define NMIF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NMIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NMIF_ASSERT(label, clk, rst, prop, msg)
`define NMIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/nmif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nmif_pkg;

  localparam int MAX_MATCHES_DEFAULT = 1024;
  localparam int CMD_W   = 2;
  localparam int LINE_W  = 20;
  localparam int COL_W   = 16;
  localparam int KEY_W   = LINE_W + COL_W;
  localparam int STEP_W  = 16;
  localparam int INDEX_W = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_LOOK,
    S_AT,
    S_STEP,
    S_MOD,
    S_FIN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LINE_W-1:0] query_line;
    logic [COL_W-1:0]  query_column;
    logic              direction_next;
    logic [STEP_W-1:0] step_count;
    logic              keep_if_one;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic [LINE_W-1:0]  match_line;
    logic [COL_W-1:0]   match_column;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/nmif_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nmif_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/nmif_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module nmif_mod_unit #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  rem
);

  localparam int CYC_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CYC_W-1:0]      cycles;
  logic [DIVIDEND_W-1:0] shreg;
  logic [DIVISOR_W-1:0]  divs;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;

  // one restoring step per cycle while busy
  always_comb begin
    trial    = {rem, shreg[DIVIDEND_W-1]};
    ge       = trial >= {1'b0, divs};
    rem_next = ge ? DIVISOR_W'(trial - {1'b0, divs}) : DIVISOR_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      cycles <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cycles <= CYC_W'(DIVIDEND_W);
      end else if (busy) begin
        cycles <= cycles - 1'b1;
        if (cycles == CYC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      divs  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= rem_next;
    end
  end

endmodule

`default_nettype wire

>>> design/nearest_match_index_finder_core.sv
// Nearest match finder over a table of match start positions, which must be
// appended in ascending order; the block itself does not enforce the order. A
// clear or append request is taken in idle, and the block stays in idle. A query
// runs a lower bound search, each probe a memory read then a compare, then a
// lookup of the found entry, a bit-serial modulo by the entry count, and a read
// of the result entry. The table memory has a single read port, and the modulo
// is done by one serial unit. The input is ready only in idle; a finished result
// waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_match_index_finder_core_assert.svh"

module nearest_match_index_finder_core #(
  parameter int MAX_MATCHES = nmif_pkg::MAX_MATCHES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  nmif_stream_if.sink   req,
  nmif_stream_if.source rsp
);

  localparam int IDX_W = $clog2(MAX_MATCHES);
  localparam int CNT_W = $clog2(MAX_MATCHES + 1);
  localparam int XW    = ((CNT_W > nmif_pkg::STEP_W) ? CNT_W : nmif_pkg::STEP_W) + 1;

  nmif_pkg::state_t state, state_next;

  logic [nmif_pkg::KEY_W-1:0] mem [MAX_MATCHES];
  logic [nmif_pkg::KEY_W-1:0] rd_data;
  logic [IDX_W-1:0]           rd_addr;

  logic [CNT_W-1:0]           total;
  logic [CNT_W-1:0]           lo;
  logic [CNT_W-1:0]           len;
  logic [CNT_W-1:0]           base;
  logic [CNT_W-1:0]           fin_i;
  logic [nmif_pkg::KEY_W-1:0] key;
  logic [nmif_pkg::STEP_W-1:0] cnt_m1;
  logic                       fwd;
  logic                       keep;
  logic                       at_cur;
  logic                       found_q;

  logic                 out_valid;
  nmif_pkg::rsp_t       out_data;

  logic                 req_ready;
  logic                 req_fire;
  logic                 mod_start;
  logic                 mod_done;
  logic [CNT_W-1:0]     mod_rem;
  logic [XW-1:0]        mod_dividend;
  logic                 out_load;

  logic [CNT_W-1:0]     half;
  logic [CNT_W-1:0]     mid;
  logic                 lt;
  logic                 stay;
  logic                 lo_end;
  logic [CNT_W-1:0]     lo_p1;
  logic [CNT_W-1:0]     i0;
  logic [CNT_W-1:0]     fin_next;
  logic [nmif_pkg::KEY_W-1:0] key_in;

  assign req.ready = req_ready;
  assign req_fire  = req.valid && req_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign key_in    = {req.data.query_line, req.data.query_column};
  assign out_load  = (state == nmif_pkg::S_DONE) && (!out_valid || rsp.ready);

  // search and step arithmetic
  always_comb begin
    half   = len >> 1;
    mid    = lo + half;
    lt     = rd_data < key;
    stay   = keep && (cnt_m1 == '0);
    lo_end = lo >= total;
    lo_p1  = (lo + CNT_W'(1) == total) ? '0 : lo + CNT_W'(1);
    if (fwd) begin
      if (lo_end) begin
        i0 = '0;
      end else if (at_cur && !stay) begin
        i0 = lo_p1;
      end else begin
        i0 = lo;
      end
      mod_dividend = XW'(i0) + XW'(cnt_m1);
    end else begin
      if (lo_end) begin
        i0 = total - CNT_W'(1);
      end else if (at_cur && stay) begin
        i0 = lo;
      end else if (lo == '0) begin
        i0 = total - CNT_W'(1);
      end else begin
        i0 = lo - CNT_W'(1);
      end
      mod_dividend = XW'(cnt_m1);
    end
    if (fwd) begin
      fin_next = mod_rem;
    end else if (mod_rem <= base) begin
      fin_next = base - mod_rem;
    end else begin
      fin_next = CNT_W'(({1'b0, base} + {1'b0, total}) - {1'b0, mod_rem});
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nmif_pkg::S_IDLE: begin
        if (req_fire && req.data.cmd == nmif_pkg::CMD_QUERY) begin
          state_next = (total == '0) ? nmif_pkg::S_DONE : nmif_pkg::S_PROBE;
        end
      end
      nmif_pkg::S_PROBE: state_next = (len == '0) ? nmif_pkg::S_LOOK : nmif_pkg::S_CMP;
      nmif_pkg::S_CMP:   state_next = nmif_pkg::S_PROBE;
      nmif_pkg::S_LOOK:  state_next = lo_end ? nmif_pkg::S_STEP : nmif_pkg::S_AT;
      nmif_pkg::S_AT:    state_next = nmif_pkg::S_STEP;
      nmif_pkg::S_STEP:  state_next = nmif_pkg::S_MOD;
      nmif_pkg::S_MOD: begin
        if (mod_done) begin
          state_next = nmif_pkg::S_FIN;
        end
      end
      nmif_pkg::S_FIN:   state_next = nmif_pkg::S_READ;
      nmif_pkg::S_READ:  state_next = nmif_pkg::S_DONE;
      nmif_pkg::S_DONE: begin
        if (out_load) begin
          state_next = nmif_pkg::S_IDLE;
        end
      end
      default: state_next = nmif_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready = 1'b0;
    mod_start = 1'b0;
    rd_addr   = mid[IDX_W-1:0];
    case (state)
      nmif_pkg::S_IDLE:  req_ready = 1'b1;
      nmif_pkg::S_LOOK:  rd_addr   = lo[IDX_W-1:0];
      nmif_pkg::S_STEP:  mod_start = 1'b1;
      nmif_pkg::S_READ:  rd_addr   = fin_i[IDX_W-1:0];
      nmif_pkg::S_DONE:  rd_addr   = fin_i[IDX_W-1:0];
      default: rd_addr = mid[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nmif_pkg::S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire) begin
        case (req.data.cmd)
          nmif_pkg::CMD_CLEAR: total <= '0;
          nmif_pkg::CMD_APPEND: begin
            if (total < CNT_W'(MAX_MATCHES)) begin
              total <= total + CNT_W'(1);
            end
          end
          default: total <= total;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (req_fire && req.data.cmd == nmif_pkg::CMD_APPEND &&
        total < CNT_W'(MAX_MATCHES)) begin
      mem[total[IDX_W-1:0]] <= key_in;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      nmif_pkg::S_IDLE: begin
        if (req_fire) begin
          key     <= key_in;
          fwd     <= req.data.direction_next;
          keep    <= req.data.keep_if_one;
          cnt_m1  <= (req.data.step_count == '0) ? '0 : req.data.step_count - 1'b1;
          lo      <= '0;
          len     <= total;
          found_q <= total != '0;
          fin_i   <= '0;
        end
      end
      nmif_pkg::S_CMP: begin
        if (lt) begin
          lo  <= mid + CNT_W'(1);
          len <= len - half - CNT_W'(1);
        end else begin
          len <= half;
        end
      end
      nmif_pkg::S_LOOK: at_cur <= 1'b0;
      nmif_pkg::S_AT:   at_cur <= rd_data == key;
      nmif_pkg::S_STEP: base   <= i0;
      nmif_pkg::S_FIN:  fin_i  <= fin_next;
      default: ;
    endcase
    if (out_load) begin
      if (found_q) begin
        out_data.found        <= 1'b1;
        out_data.match_index  <= nmif_pkg::INDEX_W'(fin_i);
        out_data.match_line   <= rd_data[nmif_pkg::KEY_W-1:nmif_pkg::COL_W];
        out_data.match_column <= rd_data[nmif_pkg::COL_W-1:0];
      end else begin
        out_data <= '0;
      end
    end
  end

  nmif_mod_unit #(
    .DIVIDEND_W (XW),
    .DIVISOR_W  (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (total),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  `NMIF_ASSERT(a_total_bound, clk, rst, total <= CNT_W'(MAX_MATCHES), "count past capacity")
  `NMIF_ASSERT(a_mod_range, clk, rst, mod_done |-> (mod_rem < total), "remainder out of range")
  `NMIF_ASSERT(a_index_range, clk, rst, (state == nmif_pkg::S_READ) |-> (fin_i < total), "bad index")
  `NMIF_ASSERT(a_empty_zero, clk, rst, (out_valid && !out_data.found) |-> (out_data == '0), "dirty miss")
  `NMIF_ASSERT_NEXT(a_done_idle, clk, rst, out_load, state == nmif_pkg::S_IDLE && out_valid, "no idle")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import nmif_pkg::*;

  localparam int TABLE_DEPTH = MAX_MATCHES_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } directed_row_t;

  logic clk;
  logic rst;

  nmif_stream_if #(.payload_t(req_t)) req_if ();
  nmif_stream_if #(.payload_t(rsp_t)) rsp_if ();

  nearest_match_index_finder_core #(.MAX_MATCHES(TABLE_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // predictor state
  logic [KEY_W-1:0] match_starts [TABLE_DEPTH];
  int unsigned match_total = 0;
  int unsigned last_index = 0;

  rsp_t expected_matches [$];
  directed_row_t dir_rows [$];
  int mismatches = 0;
  int items_sent = 0;
  int send_burst = 0;
  int recv_burst = 0;
  bit hold_start = 1'b0;
  bit hold_rsp = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(15, 0) == 0) begin
      burst = $urandom_range(40, 8);
      return 0;
    end
    return $urandom_range(17, 0);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'({$urandom, $urandom});
  endfunction

  function automatic req_t random_request(input logic [CMD_W-1:0] code);
    req_t r;
    r.cmd = code;
    r.query_line = LINE_W'($urandom);
    r.query_column = COL_W'($urandom);
    r.direction_next = 1'($urandom);
    r.step_count = STEP_W'($urandom);
    r.keep_if_one = 1'($urandom);
    return r;
  endfunction

  function automatic directed_row_t dir_row(input logic [CMD_W-1:0] code, input int line,
                                            input int column, input bit fwd, input int steps,
                                            input bit keep);
    directed_row_t row;
    row.req.cmd = code;
    row.req.query_line = LINE_W'(line);
    row.req.query_column = COL_W'(column);
    row.req.direction_next = fwd;
    row.req.step_count = STEP_W'(steps);
    row.req.keep_if_one = keep;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic directed_row_t with_result(input directed_row_t row, input bit hit_found,
                                                input int idx, input int line,
                                                input int column);
    directed_row_t res;
    res = row;
    res.typed = 1'b1;
    res.want.found = hit_found;
    res.want.match_index = INDEX_W'(idx);
    res.want.match_line = LINE_W'(line);
    res.want.match_column = COL_W'(column);
    return res;
  endfunction

  function automatic void add_row(input directed_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // applies one request to the table and works out the nearest match
  function automatic void apply_request(input req_t r, output bit gives_rsp, output rsp_t res);
    logic [KEY_W-1:0] cursor;
    int unsigned lo, span, half, mid, n, i, cnt, back;
    bit hit;
    gives_rsp = 1'b0;
    res = '0;
    cursor = {r.query_line, r.query_column};
    case (r.cmd)
      CMD_CLEAR: begin
        match_total = 0;
        last_index = 0;
      end
      CMD_APPEND: begin
        if (match_total < TABLE_DEPTH) begin
          match_starts[match_total] = cursor;
          match_total++;
        end
      end
      CMD_QUERY: begin
        gives_rsp = 1'b1;
        n = match_total;
        if (n != 0) begin
          cnt = (r.step_count == 0) ? 1 : r.step_count;
          lo = 0;
          span = n;
          while (span > 0) begin
            half = span / 2;
            mid = lo + half;
            if (match_starts[mid] < cursor) begin
              lo = mid + 1;
              span = span - half - 1;
            end else begin
              span = half;
            end
          end
          i = lo;
          hit = (i < n) && (match_starts[i] == cursor);
          if (r.direction_next) begin
            if (i >= n) i = 0;
            else if (hit && !(r.keep_if_one && cnt == 1)) i = (i + 1) % n;
            i = (i + cnt - 1) % n;
          end else begin
            if (i >= n) i = n - 1;
            else if (!(hit && r.keep_if_one && cnt == 1)) i = (i == 0) ? n - 1 : i - 1;
            back = (cnt - 1) % n;
            if (back <= i) i = i - back;
            else i = n - (back - i);
          end
          if (i >= n) i = 0;
          last_index = i;
          res.found = 1'b1;
          res.match_index = INDEX_W'(i);
          {res.match_line, res.match_column} = match_starts[i];
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    int gap;
    bit has;
    rsp_t res;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(posedge clk);
    while (!(req_if.valid && req_if.ready)) @(posedge clk);
    apply_request(r, has, res);
    if (has) expected_matches.insert(expected_matches.size(), typed ? want : res);
    items_sent++;
  endtask

  // clear, append a run of starts (ascending unless noisy), then mostly queries
  task automatic run_phase(input int entries, input int queries, input bit noisy,
                           input bit squeeze);
    req_t r;
    logic [KEY_W-1:0] key, last;
    logic [KEY_W:0] sum;
    logic [KEY_W-1:0] keys [$];
    int k, pick, kind;
    send_request(random_request(CMD_CLEAR), 1'b0, '0);
    pick = $urandom_range(4, 0);
    if (pick < 2) last = KEY_W'($urandom_range(999, 0));
    else if (pick < 4) last = rand_key() >> $urandom_range(35, 0);
    else last = rand_key();
    for (k = 0; k < entries + queries; k++) begin
      if (squeeze && k == entries) hold_start = 1'b1;
      kind = (k < entries) ? 90 : $urandom_range(99, 0);
      if (kind < 84) begin
        r = random_request(CMD_QUERY);
        pick = $urandom_range(9, 0);
        if (keys.size() != 0 && pick < 4) begin
          key = keys[$urandom_range(keys.size() - 1, 0)];
        end else if (keys.size() != 0 && pick < 6) begin
          key = keys[$urandom_range(keys.size() - 1, 0)];
          if ($urandom_range(1, 0)) key = key + KEY_W'(1);
          else key = key - KEY_W'(1);
        end else if (pick == 6) begin
          key = '0;
        end else if (pick == 7) begin
          key = '1;
        end else begin
          key = rand_key();
        end
        {r.query_line, r.query_column} = key;
        pick = $urandom_range(19, 0);
        if (pick < 10) r.step_count = STEP_W'(1);
        else if (pick < 14) r.step_count = STEP_W'($urandom_range(4, 2));
        else if (pick < 16) r.step_count = STEP_W'(match_total + $urandom_range(2, 0) - 1);
        else if (pick == 16) r.step_count = 16'hFFFF;
        else if (pick == 17) r.step_count = '0;
        else if (pick == 18) r.step_count = STEP_W'($urandom_range(3 * match_total + 1, 1));
        send_request(r, 1'b0, '0);
      end else if (kind < 90 || k < entries) begin
        pick = $urandom_range(19, 0);
        if (pick < 3) sum = {1'b0, last};
        else if (pick < 13) sum = {1'b0, last} + (KEY_W + 1)'($urandom_range(300, 1));
        else if (pick < 18) sum = {1'b0, last} + (KEY_W + 1)'($urandom_range(1 << 20, 1));
        else sum = {1'b0, last} + {5'b0, $urandom};
        key = sum[KEY_W] ? '1 : sum[KEY_W-1:0];
        if (noisy && $urandom_range(9, 0) == 0) key = rand_key();
        else last = key;
        keys.insert(keys.size(), key);
        r = random_request(CMD_APPEND);
        {r.query_line, r.query_column} = key;
        send_request(r, 1'b0, '0);
      end else if (kind < 96) begin
        send_request(random_request(CMD_UNUSED), 1'b0, '0);
      end else begin
        keys.delete();
        send_request(random_request(CMD_CLEAR), 1'b0, '0);
      end
    end
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    rsp_t got, want;
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0 || hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_rsp) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_if.valid && rsp_if.ready)) @(posedge clk);
      got = rsp_if.data;
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d index=%0d line=%0h column=%0h",
                   got.found, got.match_index, got.match_line, got.match_column);
      end else begin
        want = expected_matches.pop_front();
        if (got.found !== want.found || got.match_index !== want.match_index ||
            got.match_line !== want.match_line || got.match_column !== want.match_column) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%0d index=%0d line=%0h column=%0h, got %0d %0d %0h %0h",
                     want.found, want.match_index, want.match_line, want.match_column,
                     got.found, got.match_index, got.match_line, got.match_column);
        end
      end
    end
  end

  initial begin
    wait (hold_start);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp = 1'b0;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int pick, entries;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;

    // empty table, unused code, then a four-entry table with a duplicate and the max start
    add_row(with_result(dir_row(CMD_QUERY, 0, 0, 1, 1, 0), 0, 0, 0, 0));
    add_row(with_result(dir_row(CMD_QUERY, 'hFFFFF, 'hFFFF, 0, 'hFFFF, 1), 0, 0, 0, 0));
    add_row(dir_row(CMD_UNUSED, 'hFFFFF, 'hFFFF, 1, 'hFFFF, 1));
    add_row(dir_row(CMD_APPEND, 1, 'hA, 0, 0, 0));
    add_row(dir_row(CMD_APPEND, 1, 'hA, 1, 'hFFFF, 1));
    add_row(dir_row(CMD_APPEND, 2, 0, 0, 1, 0));
    add_row(dir_row(CMD_APPEND, 'hFFFFF, 'hFFFF, 1, 1, 1));
    add_row(with_result(dir_row(CMD_QUERY, 0, 0, 1, 1, 0), 1, 0, 1, 'hA));
    add_row(with_result(dir_row(CMD_QUERY, 'hFFFFF, 'hFFFF, 1, 1, 0), 1, 0, 1, 'hA));
    add_row(dir_row(CMD_QUERY, 1, 'hA, 1, 1, 1));
    add_row(dir_row(CMD_QUERY, 1, 'hA, 1, 1, 0));
    add_row(dir_row(CMD_QUERY, 0, 0, 0, 1, 0));
    add_row(dir_row(CMD_QUERY, 1, 'hB, 0, 1, 1));
    add_row(dir_row(CMD_QUERY, 2, 0, 0, 1, 1));
    add_row(dir_row(CMD_QUERY, 2, 0, 1, 0, 1));
    add_row(dir_row(CMD_QUERY, 2, 0, 1, 'hFFFF, 0));
    add_row(dir_row(CMD_QUERY, 1, 'hA, 0, 'hFFFF, 1));
    add_row(dir_row(CMD_QUERY, 'hFFFFF, 'hFFFE, 0, 2, 0));
    add_row(dir_row(CMD_QUERY, 'h80000, 'h8000, 1, 5, 1));
    add_row(dir_row(CMD_QUERY, 'hFFFFF, 'hFFFF, 0, 4, 1));
    add_row(dir_row(CMD_CLEAR, 'hFFFFF, 'hFFFF, 1, 'hFFFF, 1));
    add_row(with_result(dir_row(CMD_QUERY, 1, 'hA, 1, 1, 1), 0, 0, 0, 0));
    add_row(dir_row(CMD_APPEND, 'h12345, 'h6789, 0, 0, 0));
    add_row(dir_row(CMD_QUERY, 'h12345, 'h6789, 0, 3, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

    run_phase(12, 60, 1'b0, 1'b1);
    // full table, with a few appends past the end
    run_phase(TABLE_DEPTH + 3, 40, 1'b0, 1'b0);
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(9, 0);
      if (pick == 0) entries = 0;
      else if (pick < 4) entries = $urandom_range(4, 1);
      else if (pick < 9) entries = $urandom_range(40, 5);
      else entries = $urandom_range(200, 41);
      run_phase(entries, $urandom_range(40, 10), $urandom_range(5, 0) == 0, 1'b0);
    end
    req_if.valid <= 1'b0;

    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_matches.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
